// ===== rtl/egcd_pkg.sv =====
`timescale 1ns / 1ps
package egcd_pkg;
	localparam int unsigned WORD_W = 64;
	localparam int unsigned INV_W  = 32;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_INIT = 7'b0000010,
		ST_NORM = 7'b0000100,
		ST_DIV  = 7'b0001000,
		ST_MUL  = 7'b0010000,
		ST_UPD  = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;
endpackage

// ===== rtl/egcd_if.sv =====
`timescale 1ns / 1ps
interface egcd_req_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [63:0] operand_a;
	logic [63:0] operand_b;
	modport source (output valid, func, operand_a, operand_b, input ready);
	modport sink   (input valid, func, operand_a, operand_b, output ready);
endinterface

interface egcd_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] gcd_value;
	logic [63:0] coef_x;
	logic [63:0] coef_y;
	logic [31:0] inverse;
	logic        no_inverse;
	modport source (output valid, gcd_value, coef_x, coef_y, inverse, no_inverse,
		input ready);
	modport sink   (input valid, gcd_value, coef_x, coef_y, inverse, no_inverse,
		output ready);
endinterface

// ===== rtl/egcd_div.sv =====
`timescale 1ns / 1ps
// Restoring divider on magnitudes, one quotient bit per cycle.
module egcd_div import egcd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] dividend,
	input  logic [WORD_W-1:0] divisor,
	output div_ctl_t          ctl,
	output logic [WORD_W-1:0] quo,
	output logic [WORD_W-1:0] rem
);
	localparam int unsigned CW = $clog2(WORD_W + 1);
	logic [WORD_W-1:0] rem_q, quo_q, dvs_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q, done_q;
	logic [WORD_W:0]   trial;

	assign trial = {rem_q, quo_q[WORD_W-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WORD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[WORD_W]) begin
				rem_q <= trial[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[WORD_W-2:0], quo_q[WORD_W-1]};
				quo_q <= {quo_q[WORD_W-2:0], 1'b0};
			end
		end
	end

	assign ctl = '{start: start, busy: busy_q, done: done_q};
	assign quo = quo_q;
	assign rem = rem_q;
endmodule

// ===== rtl/ext_gcd_modular_inverse.sv =====
`timescale 1ns / 1ps
// Extended gcd / modular inverse engine.
// req channel (sink): func, operand_a, operand_b. rsp channel (source): gcd_value,
// coef_x, coef_y, inverse, no_inverse. A beat moves when valid and ready are high.
// func 0: extended Euclid on signed DATA_WIDTH-bit operands, truncating division.
// func 1: inverse of the low MOD_BITS bits of operand_a modulo 2^MOD_BITS; no_inverse
// is set when the operand is even or zero.
// One request at a time: req.ready is high only while the engine is idle.
// Each Euclid step uses the shared restoring divider, with its start and finish, then a
// six-pass 32x32 coefficient multiply and the update. After the request beat the engine
// runs INIT and then the steps before rsp.valid rises; the next request is taken only
// after the response beat, once the engine is back in IDLE (steps is at most about 93
// for 64-bit operands).
// The result stays in its output register until taken; a stalled receiver holds
// the engine idle-busy and blocks new requests.
// arst_n clears the sequencer and the response valid; no request is in flight after.
module ext_gcd_modular_inverse import egcd_pkg::*; #(
	parameter int unsigned DATA_WIDTH = 64,
	parameter int unsigned MOD_BITS   = 32
) (
	input  logic clk,
	input  logic arst_n,
	egcd_req_if.sink   req,
	egcd_rsp_if.source rsp
);
	localparam int unsigned HALF_W   = WORD_W / 2;
	localparam logic [2:0]  MUL_LAST = 3'd5;

	state_t            st_q;
	logic              mode_q;
	logic [WORD_W-1:0] a_q, b_q, c1x_q, c1y_q, c2x_q, c2y_q;
	logic [WORD_W-1:0] q_q, px_q, py_q;
	logic [WORD_W-1:0] ma, mb, quo, rem;
	logic              div_start, rsp_valid_q;
	logic              sw;
	div_ctl_t          dctl;
	logic [WORD_W-1:0] mmask, modv;
	logic [2:0]        mul_cnt_q;
	logic [HALF_W-1:0] mul_a, mul_b;
	logic [WORD_W-1:0] mul_c, mul_p;

	assign sw = mode_q ? 1'b0 : (DATA_WIDTH < WORD_W);

	function automatic logic [WORD_W-1:0] sx(input logic [WORD_W-1:0] v, input logic en);
		logic [WORD_W-1:0] r;
		r = v;
		if (en) begin
			for (int i = DATA_WIDTH; i < WORD_W; i++) r[i] = v[DATA_WIDTH-1];
		end
		return r;
	endfunction

	assign mmask = (WORD_W'(1) << MOD_BITS) - WORD_W'(1);
	assign modv  = WORD_W'(1) << MOD_BITS;
	assign ma = a_q[WORD_W-1] ? -a_q : a_q;
	assign mb = b_q[WORD_W-1] ? -b_q : b_q;
	assign div_start = (st_q == ST_NORM);

	egcd_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(mb), .divisor(ma), .ctl(dctl), .quo(quo), .rem(rem)
	);

	// low word of q * c from three half-width products, x passes then y passes
	always_comb begin
		mul_c = (mul_cnt_q > 3'd2) ? c1y_q : c1x_q;
		unique case (mul_cnt_q)
			3'd0, 3'd3: begin
				mul_a = q_q[HALF_W-1:0];
				mul_b = mul_c[HALF_W-1:0];
			end
			3'd1, 3'd4: begin
				mul_a = q_q[HALF_W-1:0];
				mul_b = mul_c[WORD_W-1:HALF_W];
			end
			default: begin
				mul_a = q_q[WORD_W-1:HALF_W];
				mul_b = mul_c[HALF_W-1:0];
			end
		endcase
	end

	assign mul_p = WORD_W'(mul_a) * WORD_W'(mul_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			mul_cnt_q   <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: if (req.valid) st_q <= ST_INIT;
				ST_INIT: st_q <= (sx(a_q, sw) == '0) ? ST_DONE : ST_NORM;
				ST_NORM: begin
					st_q      <= ST_DIV;
					mul_cnt_q <= '0;
				end
				ST_DIV:  if (dctl.done) st_q <= ST_MUL;
				ST_MUL: begin
					mul_cnt_q <= mul_cnt_q + 3'd1;
					if (mul_cnt_q == MUL_LAST) st_q <= ST_UPD;
				end
				ST_UPD:  st_q <= (rem == '0) ? ST_DONE : ST_NORM;
				ST_DONE: if (!rsp_valid_q) begin
					rsp_valid_q <= 1'b1;
				end else if (rsp.ready) begin
					rsp_valid_q <= 1'b0;
					st_q        <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: if (req.valid) begin
				mode_q <= req.func;
				if (req.func) begin
					a_q <= req.operand_a & mmask;
					b_q <= modv;
				end else begin
					a_q <= req.operand_a;
					b_q <= req.operand_b;
				end
				c1x_q <= WORD_W'(1); c1y_q <= '0;
				c2x_q <= '0;         c2y_q <= WORD_W'(1);
			end
			ST_INIT: begin
				a_q <= sx(a_q, sw);
				b_q <= sx(b_q, sw);
			end
			ST_DIV: if (dctl.done) begin
				q_q <= sx((a_q[WORD_W-1] ^ b_q[WORD_W-1]) ? -quo : quo, sw);
			end
			ST_MUL: begin
				priority if (mul_cnt_q == 3'd0)
					px_q <= mul_p;
				else if (mul_cnt_q < 3'd3)
					px_q <= px_q + {mul_p[HALF_W-1:0], {HALF_W{1'b0}}};
				else if (mul_cnt_q == 3'd3)
					py_q <= mul_p;
				else
					py_q <= py_q + {mul_p[HALF_W-1:0], {HALF_W{1'b0}}};
			end
			ST_UPD: begin
				c1x_q <= sx(c2x_q - px_q, sw);
				c1y_q <= sx(c2y_q - py_q, sw);
				c2x_q <= c1x_q;
				c2y_q <= c1y_q;
				b_q   <= a_q;
				a_q   <= sx(b_q[WORD_W-1] ? -rem : rem, sw);
			end
			default: ;
		endcase
	end

	assign req.ready      = (st_q == ST_IDLE);
	assign rsp.valid      = rsp_valid_q;
	assign rsp.gcd_value  = b_q;
	assign rsp.coef_x     = c2x_q;
	assign rsp.coef_y     = c2y_q;
	assign rsp.no_inverse = mode_q && (b_q != WORD_W'(1));
	assign rsp.inverse    = (mode_q && b_q == WORD_W'(1)) ? INV_W'(c2x_q & mmask) : '0;

`ifndef NO_ASSERTIONS
	a_one_job: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !req.ready) else $error("response while accepting");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		dctl.busy |-> st_q == ST_DIV) else $error("divider busy out of step");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.gcd_value))
		else $error("response dropped");
`endif
endmodule

// ===== tb/ext_gcd_modular_inverse_tb.sv =====
`timescale 1ns / 1ps
module ext_gcd_modular_inverse_tb import egcd_pkg::*; ();

	localparam int unsigned MOD_W      = 32;
	localparam int          N_RANDOM   = 1330;
	localparam int          QUIET_TAIL = 150;
	localparam longint      CYCLE_CAP  = 64'd60_000_000;
	localparam logic        FN_EGCD    = 1'b0;
	localparam logic        FN_INV     = 1'b1;

	typedef struct packed {
		logic        func;
		logic [63:0] a;
		logic [63:0] b;
	} request_t;

	typedef struct packed {
		logic [63:0] g;
		logic [63:0] x;
		logic [63:0] y;
		logic [31:0] inv;
		logic        no_inv;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	egcd_req_if req ();
	egcd_rsp_if rsp ();

	ext_gcd_modular_inverse #(.DATA_WIDTH(WORD_W), .MOD_BITS(MOD_W)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	always #6 clk = ~clk;

	request_t pending_q[$];
	answer_t  answer_q[$];
	int       n_sent = 0;
	int       n_total = 0;
	int       n_taken = 0;
	int       n_errors = 0;
	longint   cycles = 0;
	logic     long_hold = 1'b0;
	bit       hold_used = 1'b0;

	// truncating division of num by den, den nonzero
	function automatic void trunc_div(input logic [63:0] num, input logic [63:0] den,
			output logic [63:0] q, output logic [63:0] r);
		logic [63:0] mn, md, qm, rm;
		mn = num[63] ? -num : num;
		md = den[63] ? -den : den;
		qm = mn / md;
		rm = mn % md;
		q = (num[63] ^ den[63]) ? -qm : qm;
		r = num[63] ? -rm : rm;
	endfunction

	function automatic void euclid(input logic [63:0] a_in, input logic [63:0] b_in,
			output logic [63:0] g, output logic [63:0] x, output logic [63:0] y);
		logic [63:0] a, b, q, r, px, py, cx, cy, nx, ny;
		a = a_in;
		b = b_in;
		cx = 64'd1; cy = 64'd0; px = 64'd0; py = 64'd1;
		while (a != 64'd0) begin
			trunc_div(b, a, q, r);
			nx = px - q * cx;
			ny = py - q * cy;
			px = cx; py = cy;
			cx = nx; cy = ny;
			b = a;
			a = r;
		end
		g = b; x = px; y = py;
	endfunction

	function automatic answer_t predict(input request_t it);
		answer_t     ans;
		logic [63:0] m, av;
		ans = '0;
		if (it.func == FN_EGCD) begin
			euclid(it.a, it.b, ans.g, ans.x, ans.y);
		end else begin
			m = 64'd1 << MOD_W;
			av = it.a & (m - 64'd1);
			euclid(av, m, ans.g, ans.x, ans.y);
			if (ans.g == 64'd1)
				ans.inv = ans.x[31:0];
			else
				ans.no_inv = 1'b1;
		end
		return ans;
	endfunction

	function automatic logic [63:0] rand_word();
		logic [63:0] v;
		int          nb;
		v = {$urandom, $urandom};
		nb = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 40);
		if (nb < 64) begin
			v = v & ((64'd1 << nb) - 64'd1);
			if ($urandom_range(0, 1))
				v = -v;
		end
		return v;
	endfunction

	task automatic add_item(input logic f, input logic [63:0] a, input logic [63:0] b);
		request_t it;
		it.func = f;
		it.a = a;
		it.b = b;
		pending_q.push_back(it);
	endtask

	// request driver
	int gap = 0;
	always @(posedge clk or negedge arst_n) begin
		request_t it;
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.func <= 1'b0;
			req.operand_a <= '0;
			req.operand_b <= '0;
			gap = 0;
		end else begin
			if (req.valid && req.ready) begin
				it.func = req.func;
				it.a = req.operand_a;
				it.b = req.operand_b;
				answer_q.push_back(predict(it));
				n_sent++;
			end
			if (!(req.valid && !req.ready)) begin
				if (gap > 0) begin
					gap--;
					req.valid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					it = pending_q.pop_front();
					req.func <= it.func;
					req.operand_a <= it.a;
					req.operand_b <= it.b;
					req.valid <= 1'b1;
					if (n_sent < n_total - QUIET_TAIL && $urandom_range(0, 5) == 0)
						gap = $urandom_range(1, 15);
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, forces the engine to back up its input
	int hold_cnt = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_hold <= 1'b0;
			hold_cnt = 0;
		end else if (n_taken == 40 && hold_cnt == 0 && !long_hold && !hold_used) begin
			long_hold <= 1'b1;
			hold_used = 1'b1;
			hold_cnt = 3000;
		end else if (hold_cnt > 0) begin
			hold_cnt--;
			if (hold_cnt == 0)
				long_hold <= 1'b0;
		end
	end

	// response monitor
	int stall = 0;
	always @(posedge clk or negedge arst_n) begin
		answer_t e;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			stall = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				n_taken++;
				if (answer_q.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("unexpected response beat g=%h", rsp.gcd_value);
				end else begin
					e = answer_q.pop_front();
					if (rsp.gcd_value !== e.g || rsp.coef_x !== e.x || rsp.coef_y !== e.y
							|| rsp.inverse !== e.inv || rsp.no_inverse !== e.no_inv) begin
						n_errors++;
						if (n_errors <= 10)
							$display("mismatch #%0d: exp g=%h x=%h y=%h inv=%h ni=%b",
								n_taken, e.g, e.x, e.y, e.inv, e.no_inv,
								" got g=%h x=%h y=%h inv=%h ni=%b",
								rsp.gcd_value, rsp.coef_x, rsp.coef_y, rsp.inverse,
								rsp.no_inverse);
					end
				end
			end
			if (stall > 0)
				stall--;
			else if (n_sent < n_total - QUIET_TAIL && $urandom_range(0, 4) == 0)
				stall = $urandom_range(1, 15);
			rsp.ready <= !long_hold && stall == 0;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("[ext_gcd_modular_inverse] ERROR");
			$finish;
		end
	end

	initial begin
		logic [63:0] g;
		req.valid = 1'b0;
		req.func = 1'b0;
		req.operand_a = '0;
		req.operand_b = '0;
		rsp.ready = 1'b0;

		// directed
		add_item(FN_EGCD, 64'd0, 64'd0);
		add_item(FN_EGCD, 64'd0, -64'd17);
		add_item(FN_EGCD, 64'd240, 64'd46);
		add_item(FN_EGCD, -64'd240, 64'd46);
		add_item(FN_EGCD, 64'd46, -64'd240);
		add_item(FN_EGCD, -64'd1, 64'h8000_0000_0000_0000);
		add_item(FN_EGCD, 64'h8000_0000_0000_0000, -64'd1);
		add_item(FN_EGCD, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
		add_item(FN_EGCD, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
		add_item(FN_EGCD, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFE);
		add_item(FN_EGCD, 64'd4660046610375530309, 64'd7540113804746346429);
		add_item(FN_EGCD, 64'd5, 64'd0);
		add_item(FN_INV, 64'd0, 64'd5);
		add_item(FN_INV, 64'd1, 64'd0);
		add_item(FN_INV, 64'd2, 64'd0);
		add_item(FN_INV, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		add_item(FN_INV, 64'hFFFF_FFFF_0000_0000, 64'd0);
		add_item(FN_INV, 64'h0000_0001_8000_0000, 64'd0);
		add_item(FN_INV, 64'h1234_5678_9ABC_DEF1, 64'd0);
		add_item(FN_INV, -64'd3, 64'd0);
		add_item(FN_INV, 64'h7FFF_FFFF, 64'd0);

		repeat (N_RANDOM) begin
			case ($urandom_range(0, 5))
				0, 1, 2: add_item(FN_EGCD, rand_word(), rand_word());
				3: begin
					g = $urandom_range(1, 1000);
					add_item(FN_EGCD, g * $urandom_range(0, 100000),
						g * $urandom_range(0, 100000));
				end
				default: add_item(FN_INV, {$urandom, $urandom} | $urandom_range(0, 1),
					rand_word());
			endcase
		end
		n_total = pending_q.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		wait (n_sent == n_total && answer_q.size() == 0);
		repeat (400) @(posedge clk);
		if (n_errors == 0 && answer_q.size() == 0)
			$display("[ext_gcd_modular_inverse] OK");
		else
			$display("[ext_gcd_modular_inverse] ERROR");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/egcd_pkg.sv
rtl/egcd_if.sv
rtl/egcd_div.sv
rtl/ext_gcd_modular_inverse.sv
tb/ext_gcd_modular_inverse_tb.sv
